// ===== rtl/distributed_arithmetic_fir_top_macros.svh =====
// Assertion macros for the distributed-arithmetic FIR block.
// Included by the top level; no other dependencies.
`ifndef DISTRIBUTED_ARITHMETIC_FIR_TOP_MACROS_SVH
`define DISTRIBUTED_ARITHMETIC_FIR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DAFIR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dafir assertion failed");
`define DAFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dafir assertion failed");
`else
`define DAFIR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DAFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/dafir_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the distributed-arithmetic FIR block.
// No dependencies.
package dafir_pkg;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] sample;
        logic        [3:0]  tap_index;
        logic signed [15:0] coefficient;
    } req_word_t;

    typedef struct packed {
        logic signed [30:0] filtered;
        logic               saturated;
    } rsp_word_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] plane;
        logic       last;
    } wave_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_DONE
    } state_t;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_COEF = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd2;

    localparam logic [4:0] TAP_COUNT_RST     = 5'd16;
    localparam logic [5:0] INPUT_BITS_RST    = 6'd16;
    localparam logic [4:0] SEGMENT_COUNT_RST = 5'd4;

    localparam logic [5:0] INPUT_BITS_MIN = 6'd4;
    localparam logic [5:0] INPUT_BITS_MAX = 6'd32;
    localparam logic [4:0] SEGMENTS_MAX   = 5'd16;

    localparam logic signed [30:0] OUT_MAX = {1'b0, {30{1'b1}}};
    localparam logic signed [30:0] OUT_MIN = {1'b1, {30{1'b0}}};

endpackage

// ===== rtl/distributed_arithmetic_fir_top.sv =====
`timescale 1ns / 1ps
// Top level of the distributed-arithmetic FIR: config registers, plane
// launcher, row of tap cells and the accumulator. Depends on dafir_pkg,
// dafir_cell, dafir_accum and the assertion macro header.
//
//   channel | direction | handshake           | word
//   req     | in        | req_valid/req_stall | dafir_pkg::req_word_t
//   rsp     | out       | rsp_valid/rsp_stall | dafir_pkg::rsp_word_t
//   cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// A sample's result is built with one plane launched per cycle, each plane
// crossing the TAPS-deep cell row, then two accumulator stages, the done state
// and the output register. The next word is taken once the result is loaded
// into the output register; a coefficient write is taken while idle.
// Reset clears the line, the coefficients and the registers to defaults.
// A finished word waits in the output register while the next one is taken.
`include "distributed_arithmetic_fir_top_macros.svh"
module distributed_arithmetic_fir_top #(
    parameter int TAPS         = 16,
    parameter int COEF_BITS    = 16,
    parameter int LUT_ADDR_CAP = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  dafir_pkg::req_word_t                  req_word,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output dafir_pkg::rsp_word_t                  rsp_word,
    input  logic                                  cfg_we,
    input  logic [dafir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dafir_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dafir_pkg::*;

    localparam int NW   = $clog2(TAPS + 1);
    localparam int OFFW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PSW  = COEF_BITS + NW + 1;
    localparam int ACCW = PSW + 33;
    localparam int CMAX = (1 << (COEF_BITS - 1)) - 1;
    localparam int CMIN = -(1 << (COEF_BITS - 1));

    logic [4:0] tap_count_reg;
    logic [5:0] input_bits_reg;
    logic [4:0] segment_count_reg;

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] plane_reg;
    logic [4:0] plane_next;
    logic [NW-1:0] per_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    rsp_word_t  rsp_word_reg;

    logic          req_accept;
    logic          push;
    logic          coef_wr;
    logic          out_free;
    logic          load_out;
    logic          acc_done;
    rsp_word_t     acc_result;
    wave_ctl_t     launch_ctl;

    logic [NW-1:0] n_c;
    logic [4:0]    nb_m1_c;
    logic [4:0]    segs_c;
    logic [NW-1:0] per_c;
    logic [31:0]   sample_ext;
    logic          sample_sign;
    logic signed [31:0]          coef32;
    logic signed [COEF_BITS-1:0] coef_c;

    wave_ctl_t             ctl_w  [TAPS+1];
    logic [OFFW-1:0]       off_w  [TAPS+1];
    logic signed [PSW-1:0] tot_w  [TAPS+1];
    logic signed [PSW-1:0] seg_w  [TAPS+1];
    logic                  skip_w [TAPS+1];
    logic [31:0]           line_w [TAPS];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg     <= TAP_COUNT_RST;
            input_bits_reg    <= INPUT_BITS_RST;
            segment_count_reg <= SEGMENT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAP_COUNT:     tap_count_reg     <= cfg_data[4:0];
                CFG_INPUT_BITS:    input_bits_reg    <= cfg_data;
                CFG_SEGMENT_COUNT: segment_count_reg <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // clamped settings
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            n_c = NW'(1);
        end
        else if (int'(tap_count_reg) > TAPS)
        begin
            n_c = NW'(TAPS);
        end
        else
        begin
            n_c = NW'(tap_count_reg);
        end

        if (input_bits_reg < INPUT_BITS_MIN)
        begin
            nb_m1_c = 5'(INPUT_BITS_MIN - 6'd1);
        end
        else if (input_bits_reg > INPUT_BITS_MAX)
        begin
            nb_m1_c = 5'(INPUT_BITS_MAX - 6'd1);
        end
        else
        begin
            nb_m1_c = 5'(input_bits_reg - 6'd1);
        end

        if (segment_count_reg == '0)
        begin
            segs_c = 5'd1;
        end
        else if (segment_count_reg > SEGMENTS_MAX)
        begin
            segs_c = SEGMENTS_MAX;
        end
        else
        begin
            segs_c = segment_count_reg;
        end
        if (int'(segs_c) > int'(n_c))
        begin
            segs_c = 5'(n_c);
        end
    end

    // taps per segment: smallest k with k * segs >= n
    always_comb
    begin
        per_c = NW'(TAPS);
        for (int k = TAPS; k >= 1; k--)
        begin
            if (k * int'(segs_c) >= int'(n_c))
            begin
                per_c = NW'(k);
            end
        end
    end

    assign sample_sign = req_word.sample[nb_m1_c];

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            sample_ext[i] = (5'(i) > nb_m1_c) ? sample_sign : req_word.sample[i];
        end
    end

    always_comb
    begin
        coef32 = 32'(req_word.coefficient);
        if (coef32 > CMAX)
        begin
            coef32 = CMAX;
        end
        else if (coef32 < CMIN)
        begin
            coef32 = CMIN;
        end
        coef_c = COEF_BITS'(coef32);
    end

    // handshake and control
    assign req_accept = req_valid && !req_stall;
    assign push       = req_accept && (req_word.cmd == CMD_PUSH);
    assign coef_wr    = req_accept && (req_word.cmd == CMD_COEF);
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (plane_reg == nb_m1_c)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (acc_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall        = 1'b1;
        load_out         = 1'b0;
        launch_ctl.valid = 1'b0;
        launch_ctl.plane = plane_reg;
        launch_ctl.last  = (plane_reg == nb_m1_c);
        case (state_reg)
            ST_IDLE: req_stall        = 1'b0;
            ST_RUN:  launch_ctl.valid = 1'b1;
            ST_WAIT: ;
            ST_DONE: load_out         = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        plane_next = plane_reg;
        if (push)
        begin
            plane_next = '0;
        end
        else if (state_reg == ST_RUN)
        begin
            plane_next = plane_reg + 5'd1;
        end
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plane_reg     <= '0;
            per_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plane_reg     <= plane_next;
            rsp_valid_reg <= rsp_valid_next;
            if (push)
            begin
                per_reg <= per_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_word_reg <= acc_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // cell row
    assign ctl_w[0]  = launch_ctl;
    assign off_w[0]  = '0;
    assign tot_w[0]  = '0;
    assign seg_w[0]  = '0;
    assign skip_w[0] = 1'b0;

    for (genvar t = 0; t < TAPS; t++)
    begin : g_cell
        logic [31:0] line_src;

        if (t == 0)
        begin : g_head
            assign line_src = sample_ext;
        end
        else
        begin : g_body
            assign line_src = line_w[t-1];
        end

        dafir_cell #(
            .IDX          (t),
            .COEF_BITS    (COEF_BITS),
            .LUT_ADDR_CAP (LUT_ADDR_CAP),
            .NW           (NW),
            .OFFW         (OFFW),
            .PSW          (PSW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (push),
            .line_in    (line_src),
            .line_out   (line_w[t]),
            .coef_we    (coef_wr),
            .coef_index (req_word.tap_index),
            .coef_in    (coef_c),
            .tap_count  (n_c),
            .per        (per_reg),
            .ctl_in     (ctl_w[t]),
            .off_in     (off_w[t]),
            .tot_in     (tot_w[t]),
            .seg_in     (seg_w[t]),
            .skip_in    (skip_w[t]),
            .ctl_out    (ctl_w[t+1]),
            .off_out    (off_w[t+1]),
            .tot_out    (tot_w[t+1]),
            .seg_out    (seg_w[t+1]),
            .skip_out   (skip_w[t+1])
        );
    end

    dafir_accum #(
        .PSW  (PSW),
        .ACCW (ACCW)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (push),
        .ctl_in  (ctl_w[TAPS]),
        .tot_in  (tot_w[TAPS]),
        .seg_in  (seg_w[TAPS]),
        .skip_in (skip_w[TAPS]),
        .done    (acc_done),
        .result  (acc_result)
    );

    `DAFIR_ASSERT_IMPLIES(a_done_in_wait, clk, rst_n, acc_done, state_reg == ST_WAIT)
    `DAFIR_ASSERT_NEXT(a_push_starts_run, clk, rst_n, push, state_reg == ST_RUN && plane_reg == '0)
    `DAFIR_ASSERT_IMPLIES(a_run_plane_bound, clk, rst_n, state_reg == ST_RUN, plane_reg <= nb_m1_c)
    `DAFIR_ASSERT_IMPLIES(a_sat_at_rail, clk, rst_n, rsp_valid_reg && rsp_word_reg.saturated, rsp_word_reg.filtered == OUT_MAX || rsp_word_reg.filtered == OUT_MIN)
    `DAFIR_ASSERT_NEXT(a_out_only_from_done, clk, rst_n, !rsp_valid_reg && state_reg != ST_DONE, !rsp_valid_reg)

endmodule

// ===== rtl/dafir_cell.sv =====
`timescale 1ns / 1ps
// One tap cell: holds a line sample and a coefficient, adds its term to the
// plane word passing through. Depends on dafir_pkg.
module dafir_cell #(
    parameter int IDX          = 0,
    parameter int COEF_BITS    = 16,
    parameter int LUT_ADDR_CAP = 12,
    parameter int NW           = 5,
    parameter int OFFW         = 4,
    parameter int PSW          = 21
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [31:0]                  line_in,
    output logic [31:0]                  line_out,
    input  logic                         coef_we,
    input  logic [3:0]                   coef_index,
    input  logic signed [COEF_BITS-1:0]  coef_in,
    input  logic [NW-1:0]                tap_count,
    input  logic [NW-1:0]                per,
    input  dafir_pkg::wave_ctl_t         ctl_in,
    input  logic [OFFW-1:0]              off_in,
    input  logic signed [PSW-1:0]        tot_in,
    input  logic signed [PSW-1:0]        seg_in,
    input  logic                         skip_in,
    output dafir_pkg::wave_ctl_t         ctl_out,
    output logic [OFFW-1:0]              off_out,
    output logic signed [PSW-1:0]        tot_out,
    output logic signed [PSW-1:0]        seg_out,
    output logic                         skip_out
);
    import dafir_pkg::*;

    localparam bit IS_FIRST = (IDX == 0);

    logic [31:0]                 line_reg;
    logic signed [COEF_BITS-1:0] coef_reg;
    wave_ctl_t                   ctl_reg;
    logic [OFFW-1:0]             off_reg;
    logic signed [PSW-1:0]       tot_reg;
    logic signed [PSW-1:0]       seg_reg;
    logic                        skip_reg;

    logic [OFFW-1:0]       off_next;
    logic signed [PSW-1:0] tot_next;
    logic signed [PSW-1:0] seg_next;
    logic                  skip_next;

    logic                  active;
    logic [NW-1:0]         off_inc;
    logic [OFFW-1:0]       off_here;
    logic                  bit_hit;
    logic                  cap_hit;
    logic signed [PSW-1:0] term;
    logic signed [PSW-1:0] closed;

    assign active  = IDX < int'(tap_count);
    assign off_inc = NW'(off_in) + NW'(1);
    assign off_here = (IS_FIRST || off_inc == per) ? '0 : OFFW'(off_inc);
    assign bit_hit = line_reg[ctl_in.plane];
    assign cap_hit = bit_hit && (int'(off_here) >= LUT_ADDR_CAP);
    assign term    = bit_hit ? {{(PSW-COEF_BITS){coef_reg[COEF_BITS-1]}}, coef_reg} : '0;
    assign closed  = skip_in ? '0 : seg_in;

    always_comb
    begin
        off_next  = off_in;
        tot_next  = tot_in;
        seg_next  = seg_in;
        skip_next = skip_in;
        if (active)
        begin
            off_next = off_here;
            if (off_here == '0)
            begin
                tot_next  = tot_in + closed;
                seg_next  = term;
                skip_next = cap_hit;
            end
            else
            begin
                seg_next  = seg_in + term;
                skip_next = skip_in | cap_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
            coef_reg <= '0;
            ctl_reg  <= '0;
        end
        else
        begin
            if (shift_en && active)
            begin
                line_reg <= line_in;
            end
            if (coef_we && int'(coef_index) == IDX)
            begin
                coef_reg <= coef_in;
            end
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        tot_reg  <= tot_next;
        seg_reg  <= seg_next;
        skip_reg <= skip_next;
    end

    assign line_out = line_reg;
    assign ctl_out  = ctl_reg;
    assign off_out  = off_reg;
    assign tot_out  = tot_reg;
    assign seg_out  = seg_reg;
    assign skip_out = skip_reg;

endmodule

// ===== rtl/dafir_accum.sv =====
`timescale 1ns / 1ps
// Plane accumulator: closes the last segment, weights each plane sum by its
// bit position, subtracts the sign plane and saturates. Depends on dafir_pkg.
module dafir_accum #(
    parameter int PSW  = 21,
    parameter int ACCW = 54
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear,
    input  dafir_pkg::wave_ctl_t  ctl_in,
    input  logic signed [PSW-1:0] tot_in,
    input  logic signed [PSW-1:0] seg_in,
    input  logic                  skip_in,
    output logic                  done,
    output dafir_pkg::rsp_word_t  result
);
    import dafir_pkg::*;

    localparam logic signed [ACCW-1:0] ACC_HI = ACCW'(OUT_MAX);
    localparam logic signed [ACCW-1:0] ACC_LO = ACCW'(OUT_MIN);

    wave_ctl_t              ctl1_reg;
    logic signed [PSW-1:0]  psum_reg;
    logic signed [PSW-1:0]  psum_next;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [ACCW-1:0] acc_next;
    logic signed [ACCW-1:0] weighted;
    logic                   done_reg;

    assign psum_next = tot_in + (skip_in ? '0 : seg_in);
    assign weighted  = ACCW'(psum_reg) <<< ctl1_reg.plane;

    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (ctl1_reg.valid)
        begin
            acc_next = ctl1_reg.last ? acc_reg - weighted : acc_reg + weighted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            acc_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            acc_reg  <= acc_next;
            done_reg <= ctl1_reg.valid && ctl1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        psum_reg <= psum_next;
    end

    always_comb
    begin
        result.saturated = 1'b1;
        if (acc_reg > ACC_HI)
        begin
            result.filtered = OUT_MAX;
        end
        else if (acc_reg < ACC_LO)
        begin
            result.filtered = OUT_MIN;
        end
        else
        begin
            result.filtered  = acc_reg[30:0];
            result.saturated = 1'b0;
        end
    end

    assign done = done_reg;

endmodule
